[hw/rtl/dq_pkg.sv]
// ----------------------------------------------------------------------------
// dq_pkg
// Shared types and constants for the double-ended queue: action codes,
// internal command and result records, status codes, back-end states.
// ----------------------------------------------------------------------------
package dq_pkg;

   localparam int DEPTH_DEFAULT = 16;
   localparam int DATA_W        = 32;
   localparam int ACTION_W      = 3;
   localparam int STATUS_W      = 2;
   localparam int CMD_DEPTH     = 2;   // command queue between front and back
   localparam int OUT_DEPTH     = 4;   // result queue at the output

   localparam logic [ACTION_W-1:0] ACT_PUSH_FRONT = 3'd0;
   localparam logic [ACTION_W-1:0] ACT_PUSH_BACK  = 3'd1;
   localparam logic [ACTION_W-1:0] ACT_POP_FRONT  = 3'd2;
   localparam logic [ACTION_W-1:0] ACT_POP_BACK   = 3'd3;
   localparam logic [ACTION_W-1:0] ACT_LIST       = 3'd4;

   typedef enum logic [2:0] {
      OP_PUSH_FRONT,
      OP_PUSH_BACK,
      OP_POP_FRONT,
      OP_POP_BACK,
      OP_LIST,
      OP_INVALID
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK      = 2'd0,
      ST_EMPTY   = 2'd1,
      ST_FULL    = 2'd2,
      ST_INVALID = 2'd3
   } status_type;

   typedef enum logic {
      BK_RUN,
      BK_LIST
   } back_state_type;

   typedef struct packed {
      op_type              op;
      logic [DATA_W-1:0]   value;
   } cmd_type;

   typedef struct packed {
      logic [DATA_W-1:0]   item;
      status_type          status;
      logic                last;
   } rsp_type;

endpackage

[hw/rtl/dq_front.sv]
// ----------------------------------------------------------------------------
// dq_front
// Accepts requests, decodes the action code and holds the decoded commands
// in a short queue for the back end.
// ----------------------------------------------------------------------------
module dq_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   output logic                          full,
   input  logic [dq_pkg::ACTION_W-1:0]   action,
   input  logic [dq_pkg::DATA_W-1:0]     value,
   output logic                          cmd_valid,
   output dq_pkg::cmd_type               cmd,
   input  logic                          cmd_take
);
   import dq_pkg::*;

   localparam int PTR_W = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;
   localparam int CNT_W = $clog2(CMD_DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(CMD_DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(CMD_DEPTH);

   cmd_type          q_ff [CMD_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   op_type           op_dec;
   logic             wr_en;
   logic             rd_en;

   always_comb begin
      case (action)
         ACT_PUSH_FRONT: op_dec = OP_PUSH_FRONT;
         ACT_PUSH_BACK:  op_dec = OP_PUSH_BACK;
         ACT_POP_FRONT:  op_dec = OP_POP_FRONT;
         ACT_POP_BACK:   op_dec = OP_POP_BACK;
         ACT_LIST:       op_dec = OP_LIST;
         default:        op_dec = OP_INVALID;
      endcase
   end

   assign full      = (count_ff == FULL_CNT);
   assign cmd_valid = (count_ff != '0);
   assign cmd       = q_ff[rd_ptr_ff];
   assign wr_en     = push && !full;
   assign rd_en     = cmd_take && cmd_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (wr_en) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (rd_en) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      case ({wr_en, rd_en})
         2'b10:   count_in = count_ff + CNT_W'(1);
         2'b01:   count_in = count_ff - CNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         q_ff[wr_ptr_ff] <= '{op: op_dec, value: value};
      end
   end

endmodule

[hw/rtl/dq_back.sv]
// ----------------------------------------------------------------------------
// dq_back
// Executes commands against the ring store: keeps front/back indices and the
// occupancy, walks the ring for a list, and queues results for the output.
// ----------------------------------------------------------------------------
module dq_back #(
   parameter int DEPTH = dq_pkg::DEPTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             cmd_valid,
   input  dq_pkg::cmd_type  cmd,
   output logic             cmd_take,
   input  logic             rsp_pop,
   output logic             rsp_empty,
   output dq_pkg::rsp_type  rsp
);
   import dq_pkg::*;

   localparam int IDX_W     = $clog2(DEPTH);
   localparam int CNT_W     = $clog2(DEPTH + 1);
   localparam int OUT_PTR_W = (OUT_DEPTH > 1) ? $clog2(OUT_DEPTH) : 1;
   localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);
   localparam logic [IDX_W-1:0]     LAST_IDX     = IDX_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0]     FULL_CNT     = CNT_W'(DEPTH);
   localparam logic [OUT_PTR_W-1:0] OUT_LAST_PTR = OUT_PTR_W'(OUT_DEPTH - 1);
   localparam logic [OUT_CNT_W:0]   OUT_LIMIT    = (OUT_CNT_W + 1)'(OUT_DEPTH);

   function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] i);
      return (i == LAST_IDX) ? '0 : i + IDX_W'(1);
   endfunction

   function automatic logic [IDX_W-1:0] ring_prev(input logic [IDX_W-1:0] i);
      return (i == '0) ? LAST_IDX : i - IDX_W'(1);
   endfunction

   back_state_type    state_ff, state_in;
   logic [IDX_W-1:0]  front_ff, front_in;
   logic [IDX_W-1:0]  back_ff, back_in;
   logic [CNT_W-1:0]  occ_ff, occ_in;
   logic [IDX_W-1:0]  list_idx_ff, list_idx_in;
   logic [CNT_W-1:0]  list_left_ff, list_left_in;

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;
   logic              mem_we;
   logic [IDX_W-1:0]  mem_waddr;
   logic              rd_en;
   logic [IDX_W-1:0]  rd_addr;

   // result stage: status known, item arrives from the registered read
   logic              w_valid_ff, w_valid_in;
   status_type        w_status_ff, w_status_in;
   logic              w_last_ff, w_last_in;
   logic              w_mem_ff, w_mem_in;

   rsp_type               out_q_ff [OUT_DEPTH];
   logic [OUT_PTR_W-1:0]  out_wr_ff, out_rd_ff;
   logic [OUT_CNT_W-1:0]  out_cnt_ff;
   logic [OUT_CNT_W:0]    pending;
   logic                  room;
   logic                  out_re;
   logic                  is_empty;
   logic                  is_full;
   logic                  list_done;

   // count a result still in flight so the output queue never overflows
   assign pending   = {1'b0, out_cnt_ff} + {{OUT_CNT_W{1'b0}}, w_valid_ff};
   assign room      = (pending < OUT_LIMIT);
   assign is_empty  = (occ_ff == '0);
   assign is_full   = (occ_ff == FULL_CNT);
   assign list_done = (list_left_ff == CNT_W'(1));

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_RUN: begin
            if (cmd_valid && room && cmd.op == OP_LIST && !is_empty) begin
               state_in = BK_LIST;
            end
         end
         BK_LIST: begin
            if (room && list_done) begin
               state_in = BK_RUN;
            end
         end
         default: state_in = BK_RUN;
      endcase
   end

   // outputs and datapath control
   always_comb begin
      cmd_take     = 1'b0;
      front_in     = front_ff;
      back_in      = back_ff;
      occ_in       = occ_ff;
      list_idx_in  = list_idx_ff;
      list_left_in = list_left_ff;
      mem_we       = 1'b0;
      mem_waddr    = back_ff;
      rd_en        = 1'b0;
      rd_addr      = front_ff;
      w_valid_in   = 1'b0;
      w_status_in  = ST_OK;
      w_last_in    = 1'b1;
      w_mem_in     = 1'b0;
      case (state_ff)
         BK_RUN: begin
            if (cmd_valid && room) begin
               cmd_take   = 1'b1;
               w_valid_in = 1'b1;
               case (cmd.op)
                  OP_PUSH_FRONT: begin
                     if (is_full) begin
                        w_status_in = ST_FULL;
                     end else begin
                        front_in  = ring_prev(front_ff);
                        mem_we    = 1'b1;
                        mem_waddr = ring_prev(front_ff);
                        occ_in    = occ_ff + CNT_W'(1);
                     end
                  end
                  OP_PUSH_BACK: begin
                     if (is_full) begin
                        w_status_in = ST_FULL;
                     end else begin
                        back_in   = ring_next(back_ff);
                        mem_we    = 1'b1;
                        mem_waddr = back_ff;
                        occ_in    = occ_ff + CNT_W'(1);
                     end
                  end
                  OP_POP_FRONT: begin
                     if (is_empty) begin
                        w_status_in = ST_EMPTY;
                     end else begin
                        rd_en    = 1'b1;
                        rd_addr  = front_ff;
                        front_in = ring_next(front_ff);
                        occ_in   = occ_ff - CNT_W'(1);
                        w_mem_in = 1'b1;
                     end
                  end
                  OP_POP_BACK: begin
                     if (is_empty) begin
                        w_status_in = ST_EMPTY;
                     end else begin
                        rd_en    = 1'b1;
                        rd_addr  = ring_prev(back_ff);
                        back_in  = ring_prev(back_ff);
                        occ_in   = occ_ff - CNT_W'(1);
                        w_mem_in = 1'b1;
                     end
                  end
                  OP_LIST: begin
                     if (is_empty) begin
                        w_status_in = ST_EMPTY;
                     end else begin
                        // results come from the walk that follows
                        w_valid_in   = 1'b0;
                        list_idx_in  = front_ff;
                        list_left_in = occ_ff;
                     end
                  end
                  default: w_status_in = ST_INVALID;
               endcase
            end
         end
         BK_LIST: begin
            if (room) begin
               rd_en        = 1'b1;
               rd_addr      = list_idx_ff;
               list_idx_in  = ring_next(list_idx_ff);
               list_left_in = list_left_ff - CNT_W'(1);
               w_valid_in   = 1'b1;
               w_mem_in     = 1'b1;
               w_last_in    = list_done;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_RUN;
         front_ff     <= '0;
         back_ff      <= '0;
         occ_ff       <= '0;
         list_idx_ff  <= '0;
         list_left_ff <= '0;
         w_valid_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         front_ff     <= front_in;
         back_ff      <= back_in;
         occ_ff       <= occ_in;
         list_idx_ff  <= list_idx_in;
         list_left_ff <= list_left_in;
         w_valid_ff   <= w_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      w_status_ff <= w_status_in;
      w_last_ff   <= w_last_in;
      w_mem_ff    <= w_mem_in;
   end

   // ring store
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= cmd.value;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // result queue
   assign rsp_empty = (out_cnt_ff == '0);
   assign rsp       = out_q_ff[out_rd_ff];
   assign out_re    = rsp_pop && !rsp_empty;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_wr_ff  <= '0;
         out_rd_ff  <= '0;
         out_cnt_ff <= '0;
      end else begin
         if (w_valid_ff) begin
            out_wr_ff <= (out_wr_ff == OUT_LAST_PTR) ? '0 : out_wr_ff + OUT_PTR_W'(1);
         end
         if (out_re) begin
            out_rd_ff <= (out_rd_ff == OUT_LAST_PTR) ? '0 : out_rd_ff + OUT_PTR_W'(1);
         end
         case ({w_valid_ff, out_re})
            2'b10:   out_cnt_ff <= out_cnt_ff + OUT_CNT_W'(1);
            2'b01:   out_cnt_ff <= out_cnt_ff - OUT_CNT_W'(1);
            default: out_cnt_ff <= out_cnt_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (w_valid_ff) begin
         out_q_ff[out_wr_ff] <= '{item:   (w_mem_ff ? rd_data_ff : '0),
                                  status: w_status_ff,
                                  last:   w_last_ff};
      end
   end

   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= FULL_CNT)
      else $error("occupancy above depth");

   a_empty_ends_meet: assert property (@(posedge clock) disable iff (reset)
      (occ_ff == '0) |-> (front_ff == back_ff))
      else $error("front and back disagree on an empty ring");

   a_out_no_overflow: assert property (@(posedge clock) disable iff (reset)
      (w_valid_ff && out_cnt_ff == OUT_CNT_W'(OUT_DEPTH)) |-> out_re)
      else $error("result queue overflow");

   a_list_walk_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_LIST) |-> (list_left_ff != '0))
      else $error("list walk with nothing left");

   a_list_ring_frozen: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_LIST) |=> $stable(occ_ff))
      else $error("ring changed during a list walk");

endmodule

[hw/rtl/double_ended_queue.sv]
// ----------------------------------------------------------------------------
// double_ended_queue
// Bounded double-ended queue of signed 32-bit values in a ring store.
// ----------------------------------------------------------------------------
//   channel   | direction | handshake           | payload
//   request   | in        | push / full         | req_action, req_value
//   response  | out       | pop / empty         | rsp_item, rsp_status, rsp_last
//
// Push, pop and invalid commands sustain one per cycle while the result queue
// has room and no list walk runs; a result passes the command queue, execute
// and the result stage. A list gives one result per stored entry; the ring
// walk holds the command queue, since the store has a single read port.
// Reset is synchronous: indices and occupancy clear, the store itself does not.
// When pop stays low the result queue fills and further requests then fill full.
// ----------------------------------------------------------------------------
module double_ended_queue #(
   parameter int DEPTH = dq_pkg::DEPTH_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 push,
   output logic                                 full,
   input  logic [dq_pkg::ACTION_W-1:0]          req_action,
   input  logic signed [dq_pkg::DATA_W-1:0]     req_value,
   output logic                                 empty,
   input  logic                                 pop,
   output logic signed [dq_pkg::DATA_W-1:0]     rsp_item,
   output logic [dq_pkg::STATUS_W-1:0]          rsp_status,
   output logic                                 rsp_last
);
   import dq_pkg::*;

   logic    cmd_valid;
   logic    cmd_take;
   cmd_type cmd;
   rsp_type rsp;

   dq_front u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .action    (req_action),
      .value     (req_value),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_take  (cmd_take)
   );

   dq_back #(
      .DEPTH (DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_take  (cmd_take),
      .rsp_pop   (pop),
      .rsp_empty (empty),
      .rsp       (rsp)
   );

   assign rsp_item   = rsp.item;
   assign rsp_status = rsp.status;
   assign rsp_last   = rsp.last;

endmodule
